>>> rtl/polyline_raster_max_blend_top_macros.svh
// ----------------------------------------------------------------------------
// polyline_raster_max_blend_top_macros.svh
// Assertion macros shared by the polyline raster checker.
// ----------------------------------------------------------------------------
`ifndef POLYLINE_RASTER_MAX_BLEND_TOP_MACROS_SVH
`define POLYLINE_RASTER_MAX_BLEND_TOP_MACROS_SVH

// same-cycle implication, clocked on aclk, off during reset
`define PRB_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, clocked on aclk, off during reset
`define PRB_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/prb_pkg.sv
// ----------------------------------------------------------------------------
// prb_pkg
// Types and constants of the polyline raster with max blending.
// ----------------------------------------------------------------------------
package prb_pkg;

    // default geometry
    localparam int DEF_MAX_ROWS   = 256;
    localparam int DEF_MAX_COLS   = 256;
    localparam int DEF_COORD_BITS = 12;

    // pixel and register widths
    localparam int PIX_W   = 8;
    localparam int CFG_W   = 9;
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    localparam logic [CFG_W-1:0] CFG_RESET   = 9'd256;
    localparam logic [PIX_W-1:0] LINE_LEVEL  = 8'd127;
    localparam logic [PIX_W-1:0] POINT_LEVEL = 8'd255;

    // register index (paddr bit 2)
    localparam logic REG_ROWS = 1'b0;
    localparam logic REG_COLS = 1'b1;

    // command codes carried on s_tuser
    typedef enum logic [1:0] {
        CMD_START = 2'd0,
        CMD_ADD   = 2'd1,
        CMD_READ  = 2'd2
    } cmd_t;

    // sequencer states
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LINE,
        ST_POINT,
        ST_READ
    } state_t;

    // one frame access travelling down the read-modify-write pipeline
    typedef struct packed {
        logic             valid;
        logic             wr;     // max-blend write
        logic             rd;     // pixel read, produces a result
        logic             zero;   // read outside the image returns 0
        logic [PIX_W-1:0] level;
    } req_t;

endpackage

>>> rtl/polyline_raster_max_blend_top.sv
// ----------------------------------------------------------------------------
// polyline_raster_max_blend_top
// Bresenham polyline renderer into an 8-bit frame memory with max blending.
// ----------------------------------------------------------------------------
// Every plotted pixel is one read-modify-write of the single frame memory, and
// the memory pipeline takes one pixel per cycle, forwarding the last write when
// the next pixel hits the same entry. An add-point transfer that is not next to
// the previous point first walks the line pixels; every add then plots the
// point itself. A read passes the stage-2 request register, and its result
// comes out of an output register. A start transfer (and reset) runs a clearing
// pass over all MAX_ROWS*MAX_COLS entries (65536 at the defaults), one entry per
// cycle; a start transfer then plots its point. No input is taken during the
// pass while configuration writes still are.
// ----------------------------------------------------------------------------
module polyline_raster_max_blend_top #(
    parameter int MAX_ROWS   = prb_pkg::DEF_MAX_ROWS,
    parameter int MAX_COLS   = prb_pkg::DEF_MAX_COLS,
    parameter int COORD_BITS = prb_pkg::DEF_COORD_BITS
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // input stream
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // [COORD_BITS-1:0] point_row, [2*COORD_BITS-1:COORD_BITS] point_col, zero pad
    input  logic [((2*COORD_BITS+7)/8)*8-1:0] s_tdata,
    // [1:0] command
    input  logic [1:0]                    s_tuser,
    // result stream
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // [7:0] pixel_value
    output logic [prb_pkg::PIX_W-1:0]     m_tdata,
    // configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [prb_pkg::PADDR_W-1:0]   paddr,
    input  logic [prb_pkg::PDATA_W-1:0]   pwdata,
    output logic [prb_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready
);

    localparam int DEPTH = MAX_ROWS * MAX_COLS;
    localparam int AW    = $clog2(DEPTH);
    localparam int RW    = $clog2(MAX_ROWS);
    localparam int CLW   = $clog2(MAX_COLS);
    localparam int CW    = (COORD_BITS > 13) ? COORD_BITS : 13;
    localparam int DW    = COORD_BITS + 3;
    localparam int PW    = prb_pkg::PIX_W;
    localparam int FW    = prb_pkg::CFG_W;

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic signed [DW-1:0]         diff_t;

    // ------------------------------------------------------------------------
    // helpers
    // ------------------------------------------------------------------------
    function automatic logic in_image(input coord_t r, input coord_t c,
                                      input logic [FW-1:0] rows,
                                      input logic [FW-1:0] cols);
        logic [CW-1:0] rz;
        logic [CW-1:0] cz;
        rz = CW'($unsigned(r));
        cz = CW'($unsigned(c));
        return !r[COORD_BITS-1] && !c[COORD_BITS-1]
            && (rz < CW'(rows)) && (rz < CW'(MAX_ROWS))
            && (cz < CW'(cols)) && (cz < CW'(MAX_COLS));
    endfunction

    function automatic logic [AW-1:0] pix_addr(input coord_t r, input coord_t c);
        logic [CW-1:0] rz;
        logic [CW-1:0] cz;
        rz = CW'($unsigned(r));
        cz = CW'($unsigned(c));
        return AW'(rz[RW-1:0]) * AW'(MAX_COLS) + AW'(cz[CLW-1:0]);
    endfunction

    // ------------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------------
    logic [FW-1:0] rows_in_use_reg;
    logic [FW-1:0] cols_in_use_reg;
    logic          cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rows_in_use_reg <= prb_pkg::CFG_RESET;
            cols_in_use_reg <= prb_pkg::CFG_RESET;
        end else if (cfg_wr) begin
            case (paddr[2])
                prb_pkg::REG_ROWS: rows_in_use_reg <= pwdata[FW-1:0];
                prb_pkg::REG_COLS: cols_in_use_reg <= pwdata[FW-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            prb_pkg::REG_ROWS: prdata = prb_pkg::PDATA_W'(rows_in_use_reg);
            prb_pkg::REG_COLS: prdata = prb_pkg::PDATA_W'(cols_in_use_reg);
            default:           prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------------
    // input fields and sequencer registers
    // ------------------------------------------------------------------------
    coord_t in_row;
    coord_t in_col;
    logic   s_xfer;

    assign in_row = coord_t'(s_tdata[COORD_BITS-1:0]);
    assign in_col = coord_t'(s_tdata[2*COORD_BITS-1:COORD_BITS]);
    assign s_xfer = s_tvalid && s_tready;

    prb_pkg::state_t state_reg, state_next;

    coord_t        tgt_row_reg, tgt_col_reg;
    coord_t        cur_row_reg, cur_col_reg;
    coord_t        prev_row_reg, prev_col_reg;
    logic          have_prev_reg;
    diff_t         dr_reg, dc_reg, err_reg;
    logic          sr_pos_reg, sc_pos_reg;
    logic [AW-1:0] clr_addr_reg;
    logic          clr_point_reg;

    logic          m_tvalid_reg;
    logic [PW-1:0] m_tdata_reg;
    logic          slot_free;

    prb_pkg::req_t s2_req_reg;
    logic [AW-1:0] s2_addr_reg;

    assign slot_free = !m_tvalid_reg || m_tready;

    // differences to the previous point, for the adjacency test and line setup
    diff_t d_row, d_col, abs_row, abs_col;
    logic  need_line;
    logic  clr_done;
    logic  line_end;

    assign d_row     = diff_t'(in_row) - diff_t'(prev_row_reg);
    assign d_col     = diff_t'(in_col) - diff_t'(prev_col_reg);
    assign abs_row   = d_row[DW-1] ? -d_row : d_row;
    assign abs_col   = d_col[DW-1] ? -d_col : d_col;
    assign need_line = have_prev_reg && ((abs_row > diff_t'(1)) || (abs_col > diff_t'(1)));
    assign clr_done  = !s2_req_reg.valid && (clr_addr_reg == AW'(DEPTH - 1));
    assign line_end  = (cur_row_reg == tgt_row_reg) && (cur_col_reg == tgt_col_reg);

    // ------------------------------------------------------------------------
    // next state
    // ------------------------------------------------------------------------
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            prb_pkg::ST_CLEAR: begin
                if (clr_done) begin
                    state_next = clr_point_reg ? prb_pkg::ST_POINT : prb_pkg::ST_IDLE;
                end
            end
            prb_pkg::ST_IDLE: begin
                if (s_xfer) begin
                    case (s_tuser)
                        prb_pkg::CMD_START: state_next = prb_pkg::ST_CLEAR;
                        prb_pkg::CMD_ADD:
                            state_next = need_line ? prb_pkg::ST_LINE : prb_pkg::ST_POINT;
                        prb_pkg::CMD_READ:  state_next = prb_pkg::ST_READ;
                        default:            state_next = prb_pkg::ST_IDLE;
                    endcase
                end
            end
            prb_pkg::ST_LINE: begin
                if (line_end) begin
                    state_next = prb_pkg::ST_POINT;
                end
            end
            prb_pkg::ST_POINT: state_next = prb_pkg::ST_IDLE;
            prb_pkg::ST_READ: begin
                if (slot_free) begin
                    state_next = prb_pkg::ST_IDLE;
                end
            end
            default: state_next = prb_pkg::ST_IDLE;
        endcase
    end

    // ------------------------------------------------------------------------
    // outputs of the sequencer: handshake and frame access issue
    // ------------------------------------------------------------------------
    prb_pkg::req_t iss_req;
    coord_t        iss_row, iss_col;
    logic          iss_in;
    logic          clr_wr;

    always_comb begin
        s_tready      = 1'b0;
        clr_wr        = 1'b0;
        iss_row       = tgt_row_reg;
        iss_col       = tgt_col_reg;
        iss_req       = '0;
        iss_req.level = prb_pkg::POINT_LEVEL;
        case (state_reg)
            prb_pkg::ST_CLEAR: clr_wr = !s2_req_reg.valid;
            prb_pkg::ST_IDLE:  s_tready = 1'b1;
            prb_pkg::ST_LINE: begin
                iss_row       = cur_row_reg;
                iss_col       = cur_col_reg;
                iss_req.valid = 1'b1;
                iss_req.wr    = 1'b1;
                iss_req.level = prb_pkg::LINE_LEVEL;
            end
            prb_pkg::ST_POINT: begin
                iss_req.valid = 1'b1;
                iss_req.wr    = 1'b1;
            end
            prb_pkg::ST_READ: begin
                iss_req.valid = slot_free;
                iss_req.rd    = 1'b1;
            end
            default: ;
        endcase
        // plots outside the image are dropped, reads outside return 0
        iss_in = in_image(iss_row, iss_col, rows_in_use_reg, cols_in_use_reg);
        if (!iss_in) begin
            iss_req.wr   = 1'b0;
            iss_req.zero = 1'b1;
            if (!iss_req.rd) begin
                iss_req.valid = 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // sequencer and line-walker registers
    // ------------------------------------------------------------------------
    diff_t e2;
    logic  step_row, step_col;
    diff_t err_step;

    assign e2       = err_reg <<< 1;
    assign step_row = e2 > -dc_reg;
    assign step_col = e2 < dr_reg;
    assign err_step = err_reg - (step_row ? dc_reg : diff_t'(0))
                              + (step_col ? dr_reg : diff_t'(0));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= prb_pkg::ST_CLEAR;
            clr_addr_reg  <= '0;
            clr_point_reg <= 1'b0;
            have_prev_reg <= 1'b0;
            prev_row_reg  <= '0;
            prev_col_reg  <= '0;
        end else begin
            state_reg <= state_next;
            if (s_xfer) begin
                clr_addr_reg  <= '0;
                clr_point_reg <= (s_tuser == prb_pkg::CMD_START);
            end else if (clr_wr) begin
                clr_addr_reg <= clr_addr_reg + AW'(1);
            end
            if (state_reg == prb_pkg::ST_POINT) begin
                prev_row_reg  <= tgt_row_reg;
                prev_col_reg  <= tgt_col_reg;
                have_prev_reg <= 1'b1;
            end
        end
    end

    // target and line setup on every input transfer, one Bresenham step per line cycle
    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            tgt_row_reg <= in_row;
            tgt_col_reg <= in_col;
            cur_row_reg <= prev_row_reg;
            cur_col_reg <= prev_col_reg;
            dr_reg      <= abs_row;
            dc_reg      <= abs_col;
            err_reg     <= abs_row - abs_col;
            sr_pos_reg  <= prev_row_reg < in_row;
            sc_pos_reg  <= prev_col_reg < in_col;
        end else if (state_reg == prb_pkg::ST_LINE) begin
            err_reg <= err_step;
            if (step_row) begin
                cur_row_reg <= sr_pos_reg ? cur_row_reg + coord_t'(1)
                                          : cur_row_reg - coord_t'(1);
            end
            if (step_col) begin
                cur_col_reg <= sc_pos_reg ? cur_col_reg + coord_t'(1)
                                          : cur_col_reg - coord_t'(1);
            end
        end
    end

    // ------------------------------------------------------------------------
    // frame memory: read at issue, blend and write in the cycle after
    // ------------------------------------------------------------------------
    logic [PW-1:0] frame_mem [DEPTH];
    logic [PW-1:0] rd_data_reg;
    logic [AW-1:0] iss_addr;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [PW-1:0] mem_wdata;

    logic          fwd_valid_reg;
    logic [AW-1:0] fwd_addr_reg;
    logic [PW-1:0] fwd_data_reg;
    logic [PW-1:0] old_pix;

    assign iss_addr = pix_addr(iss_row, iss_col);

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            frame_mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= frame_mem[iss_addr];
    end

    // stage 2 request
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_req_reg <= '0;
        end else begin
            s2_req_reg <= iss_req;
        end
    end

    always_ff @(posedge aclk) begin
        s2_addr_reg <= iss_addr;
    end

    // the read issued with last cycle's write returned stale data: forward it
    assign old_pix = (fwd_valid_reg && (fwd_addr_reg == s2_addr_reg)) ? fwd_data_reg
                                                                      : rd_data_reg;

    always_comb begin
        mem_we    = clr_wr;
        mem_waddr = clr_addr_reg;
        mem_wdata = '0;
        if (s2_req_reg.valid) begin
            mem_we    = s2_req_reg.wr;
            mem_waddr = s2_addr_reg;
            mem_wdata = (old_pix > s2_req_reg.level) ? old_pix : s2_req_reg.level;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fwd_valid_reg <= 1'b0;
        end else begin
            fwd_valid_reg <= mem_we;
        end
    end

    always_ff @(posedge aclk) begin
        fwd_addr_reg <= mem_waddr;
        fwd_data_reg <= mem_wdata;
    end

    // ------------------------------------------------------------------------
    // result register
    // ------------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (s2_req_reg.valid && s2_req_reg.rd) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s2_req_reg.valid && s2_req_reg.rd) begin
            m_tdata_reg <= s2_req_reg.zero ? '0 : old_pix;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

>>> rtl/prb_checker.sv
// ----------------------------------------------------------------------------
// prb_checker
// Port-level checks on the polyline raster, bound to the top level.
// ----------------------------------------------------------------------------
`include "polyline_raster_max_blend_top_macros.svh"

module prb_checker (
    input logic                      aclk,
    input logic                      aresetn,
    input logic                      s_tvalid,
    input logic                      s_tready,
    input logic [1:0]                s_tuser,
    input logic                      m_tvalid,
    input logic                      m_tready,
    input logic [prb_pkg::PIX_W-1:0] m_tdata
);

    logic cmd_xfer;

    // a transfer that does work on the frame
    assign cmd_xfer = s_tvalid && s_tready
        && (s_tuser inside {prb_pkg::CMD_START, prb_pkg::CMD_ADD, prb_pkg::CMD_READ});

    // the clearing pass after reset keeps the input closed
    `PRB_ASSERT_IMP(a_reset_clears, $past(!aresetn), !s_tready, "input open right after reset")

    // every real command leaves the sequencer busy and the input closed right after it
    `PRB_ASSERT_NXT(a_cmd_busy, cmd_xfer, !s_tready, "input open right after a command")

    // a result needs a fresh read, so none follows a taken result directly
    `PRB_ASSERT_NXT(a_result_gap, m_tvalid && m_tready, !m_tvalid, "back-to-back results")

    // a stalled result holds
    `PRB_ASSERT_NXT(a_result_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata),
                    "stalled result changed")

endmodule

bind polyline_raster_max_blend_top prb_checker u_prb_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
